@@ design/default_transition_dfa_scanner_defines.svh @@
// Assertion macros shared by the scanner RTL.
`ifndef DEFAULT_TRANSITION_DFA_SCANNER_DEFINES_SVH
`define DEFAULT_TRANSITION_DFA_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DTS_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DTS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dts_pkg.sv @@
`default_nettype none

package dts_pkg;

  localparam int STATES  = 256;
  localparam int SYMBOLS = 256;
  localparam int RULES   = 16;

  localparam int STATE_W = 8;
  localparam int SYM_W   = 8;
  localparam int RULE_W  = 16;
  localparam int CNT_W   = 32;
  localparam int KIND_W  = 2;

  localparam int PADDR_W = 2;
  localparam int APB_DW  = 32;
  localparam logic [PADDR_W-1:0] REG_START_STATE = PADDR_W'(0);

  localparam int LAB_AW = STATE_W + SYM_W;
  localparam int LAB_W  = STATE_W + 1;
  localparam int INFO_AW = STATE_W;
  localparam int INFO_W = STATE_W + RULE_W;

  localparam int STEP_W = $clog2(STATES + 1);
  localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(STATES);

  localparam logic [RULE_W-1:0] RULE_MASK =
    (RULES >= RULE_W) ? {RULE_W{1'b1}} : RULE_W'((64'd1 << RULES) - 64'd1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LABEL   = 2'd0,
    KIND_INFO    = 2'd1,
    KIND_SCAN    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_MASK = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ design/dts_ram.sv @@
`default_nettype none

module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/default_transition_dfa_scanner.sv @@
// Channel  Handshake            Beat
// cfg      psel/penable/pready  start_state write or read over APB
// in       in_valid/in_ready    one load, scan or restart item
// out      out_valid/out_ready  state after the item, flags, counts and rule hits
//
// Table writes and restart go from IDLE through FIN and back to IDLE.
// A scan walks IDLE, LOOK, MASK and FIN, with one labeled-table lookup per default pointer
// followed, plus one; a chain error skips the mask step after 257 lookups.
// After reset, in_ready stays low while the 65536 labeled-table entries and the
// state info are cleared; cfg writes are taken meanwhile.
// A stalled out beat holds the next result in FIN; in_ready stays low until it drains.
`default_nettype none

module default_transition_dfa_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dts_pkg::PADDR_W-1:0]   paddr,
  input  logic [dts_pkg::APB_DW-1:0]    pwdata,
  output logic [dts_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dts_pkg::KIND_W-1:0]    kind,
  input  logic [dts_pkg::STATE_W-1:0]   state_index,
  input  logic [dts_pkg::SYM_W-1:0]     symbol,
  input  logic [dts_pkg::STATE_W-1:0]   target_state,
  input  logic                          label_valid,
  input  logic [dts_pkg::RULE_W-1:0]    accept_rules,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dts_pkg::STATE_W-1:0]   state_after,
  output logic                          accepting,
  output logic [dts_pkg::CNT_W-1:0]     match_count,
  output logic [dts_pkg::CNT_W-1:0]     symbol_count,
  output logic [dts_pkg::RULE_W-1:0]    rule_hits,
  output logic                          chain_error
);
  import dts_pkg::*;

`include "default_transition_dfa_scanner_defines.svh"

  state_t              fsm;
  logic                clearing;
  logic [LAB_AW-1:0]   clear_cnt;
  logic [STATE_W-1:0]  start_state;
  logic [STATE_W-1:0]  cur_state;
  logic [STATE_W-1:0]  tgt_reg;
  logic [SYM_W-1:0]    sym_reg;
  logic [CNT_W-1:0]    hits;
  logic [CNT_W-1:0]    scanned;
  logic [RULE_W-1:0]   flags;
  logic                acc_flag;
  logic                err_flag;
  logic [STEP_W-1:0]   steps;

  logic                lab_we;
  logic [LAB_AW-1:0]   lab_waddr;
  logic [LAB_W-1:0]    lab_wdata;
  logic                lab_re;
  logic [LAB_AW-1:0]   lab_raddr;
  logic [LAB_W-1:0]    lab_rdata;
  logic                info_we;
  logic [INFO_AW-1:0]  info_waddr;
  logic [INFO_W-1:0]   info_wdata;
  logic                info_re;
  logic [INFO_AW-1:0]  info_raddr;
  logic [INFO_W-1:0]   info_rdata;

  logic                accept;
  logic                state_ok;
  logic                sym_ok;
  logic                lab_hit;
  logic [STATE_W-1:0]  lab_tgt;
  logic [STATE_W-1:0]  dflt_ptr;
  logic [RULE_W-1:0]   land_mask;
  logic                out_free;
  logic                apb_write;

  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == REG_START_STATE) ? APB_DW'(start_state) : '0;

  assign in_ready  = (fsm == ST_IDLE) && !clearing;
  assign accept    = in_valid && in_ready;
  assign state_ok  = 32'(state_index) < STATES;
  assign sym_ok    = 32'(symbol) < SYMBOLS;
  assign lab_hit   = lab_rdata[LAB_W-1];
  assign lab_tgt   = lab_rdata[STATE_W-1:0];
  assign dflt_ptr  = info_rdata[INFO_W-1 -: STATE_W];
  assign land_mask = info_rdata[RULE_W-1:0];
  assign out_free  = !out_valid || out_ready;

  dts_ram #(.WIDTH(LAB_W), .DEPTH(1 << LAB_AW)) u_lab_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (lab_waddr),
    .wdata (lab_wdata),
    .re    (lab_re),
    .raddr (lab_raddr),
    .rdata (lab_rdata)
  );

  dts_ram #(.WIDTH(INFO_W), .DEPTH(1 << INFO_AW)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .re    (info_re),
    .raddr (info_raddr),
    .rdata (info_rdata)
  );

  always_comb begin
    lab_we     = 1'b0;
    lab_waddr  = clear_cnt;
    lab_wdata  = '0;
    lab_re     = 1'b0;
    lab_raddr  = {cur_state, symbol};
    info_we    = 1'b0;
    info_waddr = clear_cnt[INFO_AW-1:0];
    info_wdata = '0;
    info_re    = 1'b0;
    info_raddr = cur_state;
    if (clearing) begin
      lab_we  = 1'b1;
      info_we = 1'b1;
    end else if (accept) begin
      unique case (kind_t'(kind))
        KIND_LABEL: begin
          lab_we    = state_ok && sym_ok;
          lab_waddr = {state_index, symbol};
          lab_wdata = label_valid ? {1'b1, target_state} : '0;
        end
        KIND_INFO: begin
          info_we    = state_ok;
          info_waddr = state_index;
          info_wdata = {target_state, accept_rules & RULE_MASK};
        end
        KIND_SCAN: begin
          lab_re  = 1'b1;
          info_re = 1'b1;
        end
        KIND_RESTART: begin
        end
      endcase
    end else if (fsm == ST_LOOK) begin
      if (lab_hit) begin
        info_re    = 1'b1;
        info_raddr = lab_tgt;
      end else if (steps != STEP_LIMIT) begin
        lab_re     = 1'b1;
        lab_raddr  = {dflt_ptr, sym_reg};
        info_re    = 1'b1;
        info_raddr = dflt_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm         <= ST_IDLE;
      clearing    <= 1'b1;
      clear_cnt   <= '0;
      start_state <= '0;
      cur_state   <= '0;
      hits        <= '0;
      scanned     <= '0;
      flags       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (apb_write && paddr == REG_START_STATE) begin
        start_state <= pwdata[STATE_W-1:0];
      end
      if (clearing) begin
        clear_cnt <= clear_cnt + LAB_AW'(1);
        if (&clear_cnt) begin
          clearing <= 1'b0;
        end
      end
      if (fsm == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (fsm)
        ST_IDLE: begin
          if (accept) begin
            if (kind == KIND_SCAN) begin
              scanned <= sat_inc(scanned);
              fsm     <= ST_LOOK;
            end else begin
              if (kind == KIND_RESTART) begin
                cur_state <= start_state;
                hits      <= '0;
                scanned   <= '0;
                flags     <= '0;
              end
              fsm <= ST_FIN;
            end
          end
        end
        ST_LOOK: begin
          if (lab_hit) begin
            fsm <= ST_MASK;
          end else if (steps == STEP_LIMIT) begin
            fsm <= ST_FIN;
          end
        end
        ST_MASK: begin
          cur_state <= tgt_reg;
          if (land_mask != '0) begin
            hits  <= sat_inc(hits);
            flags <= flags | land_mask;
          end
          fsm <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            fsm <= ST_IDLE;
          end
        end
        default: fsm <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_reg  <= symbol;
      steps    <= '0;
      acc_flag <= 1'b0;
      err_flag <= 1'b0;
    end
    if (fsm == ST_LOOK) begin
      if (lab_hit) begin
        tgt_reg <= lab_tgt;
      end else if (steps == STEP_LIMIT) begin
        err_flag <= 1'b1;
      end else begin
        steps <= steps + STEP_W'(1);
      end
    end
    if (fsm == ST_MASK) begin
      acc_flag <= land_mask != '0;
    end
    if (fsm == ST_FIN && out_free) begin
      state_after  <= cur_state;
      accepting    <= acc_flag;
      match_count  <= hits;
      symbol_count <= scanned;
      rule_hits    <= flags;
      chain_error  <= err_flag;
    end
  end

  `DTS_CHECK_NOW(a_clear_blocks_in, clearing, !in_ready, "input beat taken during clear")
  `DTS_CHECK_NOW(a_out_flags_excl, out_valid, !(accepting && chain_error),
                 "accepting and chain_error both set")
  `DTS_CHECK_NOW(a_steps_bound, fsm == ST_LOOK, steps <= STEP_LIMIT,
                 "chain walk ran past its limit")
  `DTS_CHECK_NEXT(a_scanned_mono, !(accept && kind == KIND_RESTART),
                  scanned >= $past(scanned), "symbol count dropped without restart")
  `DTS_CHECK_NEXT(a_err_keeps_state, fsm == ST_LOOK && !lab_hit && steps == STEP_LIMIT,
                  cur_state == $past(cur_state) && fsm == ST_FIN,
                  "chain error moved the current state")

endmodule

`default_nettype wire

@@ test/default_transition_dfa_scanner_test.sv @@
`default_nettype none

module default_transition_dfa_scanner_test;
  import dts_pkg::*;

  localparam int ALPHA          = 16;
  localparam int LONG_HOLD_AT   = 900;
  localparam int LONG_HOLD      = 600;
  localparam int SETTLE         = 8;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    kind_t              kind;
    logic [STATE_W-1:0] sidx;
    logic [SYM_W-1:0]   sym;
    logic [STATE_W-1:0] tgt;
    logic               lval;
    logic [RULE_W-1:0]  rules;
  } scan_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] nxt;
    logic               acc;
    logic [CNT_W-1:0]   match_cnt;
    logic [CNT_W-1:0]   symbols;
    logic [RULE_W-1:0]  hits;
    logic               err;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = '0;
  logic [STATE_W-1:0]  state_index = '0;
  logic [SYM_W-1:0]    symbol = '0;
  logic [STATE_W-1:0]  target_state = '0;
  logic                label_valid = 1'b0;
  logic [RULE_W-1:0]   accept_rules = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATE_W-1:0]  state_after;
  logic                accepting;
  logic [CNT_W-1:0]    match_count;
  logic [CNT_W-1:0]    symbol_count;
  logic [RULE_W-1:0]   rule_hits;
  logic                chain_error;

  default_transition_dfa_scanner dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .state_index(state_index), .symbol(symbol), .target_state(target_state),
    .label_valid(label_valid), .accept_rules(accept_rules),
    .out_valid(out_valid), .out_ready(out_ready), .state_after(state_after),
    .accepting(accepting), .match_count(match_count),
    .symbol_count(symbol_count), .rule_hits(rule_hits), .chain_error(chain_error)
  );

  always #6 clk = ~clk;

  bit [STATE_W:0]    label_tbl [STATES][SYMBOLS];
  bit [STATE_W-1:0]  default_ptr [STATES];
  bit [RULE_W-1:0]   state_rules [STATES];
  bit [STATE_W-1:0]  cur_state;
  bit [STATE_W-1:0]  start_cfg;
  bit [CNT_W-1:0]    accept_total;
  bit [CNT_W-1:0]    scan_total;
  bit [RULE_W-1:0]   rules_seen;

  scan_item_t   scan_items [$];
  scan_result_t expected_scans [$];
  scan_item_t   on_wire;

  int items_queued = 0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;
  int quiet_cycles = 0;

  function automatic bit [CNT_W-1:0] saturate_up(input bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic scan_result_t advance_automaton(input scan_item_t it);
    scan_result_t r;
    bit [STATE_W-1:0] walk;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (it.kind)
      KIND_LABEL: begin
        label_tbl[it.sidx][it.sym] = it.lval ? {1'b1, it.tgt} : '0;
      end
      KIND_INFO: begin
        default_ptr[it.sidx] = it.tgt;
        state_rules[it.sidx] = it.rules & RULE_MASK;
      end
      KIND_SCAN: begin
        scan_total = saturate_up(scan_total);
        walk = cur_state;
        for (int step = 0; step <= STATES && !hit; step++) begin
          if (label_tbl[walk][it.sym][STATE_W]) hit = 1'b1;
          else walk = default_ptr[walk];
        end
        if (hit) begin
          cur_state = label_tbl[walk][it.sym][STATE_W-1:0];
          if (state_rules[cur_state] != '0) begin
            r.acc = 1'b1;
            accept_total = saturate_up(accept_total);
            rules_seen |= state_rules[cur_state];
          end
        end else begin
          r.err = 1'b1;
        end
      end
      default: begin
        cur_state = start_cfg;
        accept_total = '0;
        scan_total = '0;
        rules_seen = '0;
      end
    endcase
    r.nxt = cur_state;
    r.match_cnt = accept_total;
    r.symbols = scan_total;
    r.hits = rules_seen;
    return r;
  endfunction

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d, %s: got %0h, expected %0h", results_seen, what, got,
             want);
    mismatches++;
  endtask

  task automatic push_item(input kind_t k, input int unsigned sidx, input int unsigned sym,
                           input int unsigned tgt, input int unsigned lval,
                           input int unsigned rules);
    scan_item_t it;
    it.kind = k;
    it.sidx = STATE_W'(sidx);
    it.sym = SYM_W'(sym);
    it.tgt = STATE_W'(tgt);
    it.lval = lval[0];
    it.rules = RULE_W'(rules);
    scan_items.insert(scan_items.size(), it);
    items_queued++;
  endtask

  task automatic drain();
    while (items_sent != items_queued || expected_scans.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_start_state(input logic [STATE_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_START_STATE;
    pwdata <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    start_cfg = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[STATE_W-1:0] !== val)
      report_mismatch("start_state readback", longint'(prdata[STATE_W-1:0]), longint'(val));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic scan_phase(input int count);
    int pick;
    int s;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, STATES - 1);
      if (pick < 72)
        push_item(KIND_SCAN, $urandom, $urandom_range(0, ALPHA - 1), $urandom, $urandom,
                  $urandom);
      else if (pick < 76)
        push_item(KIND_SCAN, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 84)
        push_item(KIND_LABEL, s, $urandom_range(0, ALPHA - 1), $urandom,
                  ($urandom_range(0, 99) < 85) ? 1 : 0, $urandom);
      else if (pick < 88)
        push_item(KIND_LABEL, s, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 93)
        push_item(KIND_INFO, s, $urandom, (s == 0) ? 0 : $urandom_range(0, s - 1), $urandom,
                  $urandom_range(0, 1) ? $urandom : 0);
      else if (pick < 95)
        push_item(KIND_INFO, s, $urandom, $urandom, $urandom, $urandom);
      else
        push_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_scans.insert(expected_scans.size(), advance_automaton(on_wire));
        items_sent++;
        tx_gap = idle_len(tx_calm);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap == 0 && scan_items.size() != 0) begin
          on_wire = scan_items.pop_front();
          in_valid <= 1'b1;
          kind <= on_wire.kind;
          state_index <= on_wire.sidx;
          symbol <= on_wire.sym;
          target_state <= on_wire.tgt;
          label_valid <= on_wire.lval;
          accept_rules <= on_wire.rules;
        end else begin
          in_valid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_scans.size() == 0) begin
          report_mismatch("beat with nothing expected", longint'(state_after), 0);
        end else begin
          want = expected_scans.pop_front();
          if (state_after !== want.nxt)
            report_mismatch("state_after", longint'(state_after), longint'(want.nxt));
          if (accepting !== want.acc)
            report_mismatch("accepting", longint'(accepting), longint'(want.acc));
          if (match_count !== want.match_cnt)
            report_mismatch("match_count", longint'(match_count), longint'(want.match_cnt));
          if (symbol_count !== want.symbols)
            report_mismatch("symbol_count", longint'(symbol_count), longint'(want.symbols));
          if (rule_hits !== want.hits)
            report_mismatch("rule_hits", longint'(rule_hits), longint'(want.hits));
          if (chain_error !== want.err)
            report_mismatch("chain_error", longint'(chain_error), longint'(want.err));
        end
        rx_hold = (results_seen == LONG_HOLD_AT) ? LONG_HOLD : idle_len(rx_calm);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_ready <= (rx_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int s;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_start_state(8'h00);

    // small automaton: root 0 loops on itself, 1 and 255 fall back
    push_item(KIND_INFO, 'h00, 'h00, 'h00, 0, 'h0000);
    push_item(KIND_INFO, 'h01, 'hFF, 'h00, 1, 'hFFFF);
    push_item(KIND_INFO, 'hFF, 'h00, 'h01, 0, 'h8001);
    push_item(KIND_LABEL, 'h00, 'h00, 'h01, 1, 'h0000);
    push_item(KIND_LABEL, 'h00, 'hFF, 'hFF, 1, 'hFFFF);
    push_item(KIND_LABEL, 'hFF, 'hAA, 'h00, 1, 'h0000);
    push_item(KIND_LABEL, 'h80, 'h7F, 'h55, 1, 'h5A5A);
    push_item(KIND_SCAN, 'h00, 'h00, 'h00, 0, 'h0000);
    push_item(KIND_SCAN, 'hFF, 'hFF, 'hFF, 1, 'hFFFF);
    push_item(KIND_SCAN, 'h00, 'hAA, 'h00, 0, 'h0000);
    // no label anywhere on the chain: error, state held
    push_item(KIND_SCAN, 'h00, 'h55, 'h00, 0, 'h0000);
    push_item(KIND_LABEL, 'h00, 'h00, 'hFF, 0, 'hFFFF);
    push_item(KIND_SCAN, 'h00, 'h00, 'h00, 0, 'h0000);
    push_item(KIND_RESTART, 'hFF, 'hFF, 'hFF, 1, 'hFFFF);
    push_item(KIND_SCAN, 'h00, 'hFF, 'h00, 0, 'h0000);
    drain();

    // load every state: default pointers lead toward the root
    for (int st = 0; st < STATES; st++)
      push_item(KIND_INFO, st, $urandom, (st == 0) ? 0 : $urandom_range(0, st - 1), $urandom,
                ($urandom_range(0, 3) == 0) ? $urandom : 0);
    for (int sy = 0; sy < ALPHA; sy++)
      push_item(KIND_LABEL, 0, sy, $urandom, 1, $urandom);
    for (int n = 0; n < 100; n++) begin
      s = $urandom_range(0, STATES - 1);
      push_item(KIND_LABEL, s, $urandom_range(0, ALPHA - 1), $urandom, 1, $urandom);
    end
    push_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom, $urandom);
    drain();

    write_start_state(8'hFF);
    push_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom, $urandom);
    scan_phase(300);
    drain();

    write_start_state(STATE_W'($urandom_range(1, 254)));
    push_item(KIND_RESTART, $urandom, $urandom, $urandom, $urandom, $urandom);
    scan_phase(300);
    drain();

    write_start_state(8'h00);
    scan_phase(300);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/dts_pkg.sv
design/dts_ram.sv
design/default_transition_dfa_scanner.sv
test/default_transition_dfa_scanner_test.sv
